// ===== hdl/cmt_pkg.sv =====
// Package with shared types and constants of the Carmichael number test unit.
package cmt_pkg;
   localparam int NUMBER_WIDTH_DEFAULT = 31;
   localparam logic [15:0] DENSE_LIMIT_RESET = 16'd100;
   localparam logic [15:0] SPARSE_LIMIT_RESET = 16'd1000;
   localparam logic [7:0] SPARSE_STRIDE_RESET = 8'd10;
   localparam logic [1:0] REG_DENSE_LIMIT = 2'd0;
   localparam logic [1:0] REG_SPARSE_LIMIT = 2'd1;
   localparam logic [1:0] REG_SPARSE_STRIDE = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV3, ST_TDCHK, ST_TDA, ST_TDB, ST_AINIT, ST_ACHK,
      ST_GCD, ST_POW, ST_MR, ST_MB, ST_NEXT, ST_FIN
   } state_type;
endpackage

// ===== hdl/carmichael_number_test_unit.sv =====
// Top level of the Carmichael number test unit with its shared modular unit.
//
// An item carries one candidate on the req_ channel; it is accepted when
// req_valid is high and req_stall is low. The unit then works on it alone
// and holds req_stall high until the result item is placed in the output
// register. One result item leaves on the rsp_ channel for every item.
// All remainders and modular products go through one shared
// shift-and-subtract unit. Small or even candidates go straight to the
// final state; for the others, trial division runs up to sqrt(n), and a
// composite then gets a gcd for each base and a modular power for each
// base coprime to it, within the dense and sparse limits.
// The csr_ channel writes the dense limit, the sparse limit and the stride;
// it is always ready and must be used only while the unit is idle.
// Synchronous reset restores the register defaults and drops any result.
// While the receiver stalls, the result item holds; a finished item waits
// in its final state until the output register is free.
module carmichael_number_test_unit #(
   parameter int NUMBER_WIDTH = cmt_pkg::NUMBER_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [NUMBER_WIDTH-1:0] req_candidate,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_is_carmichael,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [15:0]             csr_wdata
);
   import cmt_pkg::*;

   localparam int W = NUMBER_WIDTH;
   localparam int AW = (W > 18) ? W : 18;
   localparam int SW = 2 * AW;
   localparam int CW = (W > 1) ? $clog2(W) : 1;

   state_type state_ff, state_in;
   logic [15:0] dense_ff, dense_in, sparse_ff, sparse_in;
   logic [7:0] stride_ff, stride_in;
   logic [W-1:0] n_ff, n_in, gx_ff, gx_in, gy_ff, gy_in;
   logic [W-1:0] r_ff, r_in, b_ff, b_in, e_ff, e_in, acc_ff, acc_in;
   logic [AW-1:0] d_ff, d_in, a_ff, a_in;
   logic [SW-1:0] sq_ff, sq_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic run_ff, run_in, phase_ff, phase_in, res_ff, res_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_data_ff, rsp_data_in;

   logic u_active, u_mul, u_done;
   logic [W-1:0] u_x, u_y, u_m, u_res;
   logic [W:0] t1, t2;
   logic [AW-1:0] n_ext, a_limit, a_step;
   logic a_ok, out_free, accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_is_carmichael = rsp_data_ff;
   assign accept = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign n_ext = AW'(n_ff);
   assign a_limit = phase_ff ? AW'(sparse_ff) : AW'(dense_ff);
   assign a_step = phase_ff ? ((stride_ff == 8'd0) ? AW'(1) : AW'(stride_ff)) : AW'(1);
   assign a_ok = (a_ff < n_ext) && (a_ff <= a_limit);

   // Operand selection for the shared unit.
   always_comb begin
      u_active = 1'b0;
      u_mul = 1'b0;
      u_x = n_ff;
      u_y = b_ff;
      u_m = n_ff;
      unique case (state_ff)
         ST_DIV3: begin
            u_active = 1'b1;
            u_m = W'(3);
         end
         ST_TDA: begin
            u_active = 1'b1;
            u_m = d_ff[W-1:0];
         end
         ST_TDB: begin
            u_active = 1'b1;
            u_m = W'(d_ff + AW'(2));
         end
         ST_GCD: begin
            u_active = (gy_ff != '0);
            u_x = gx_ff;
            u_m = gy_ff;
         end
         ST_MR: begin
            u_active = 1'b1;
            u_mul = 1'b1;
            u_x = r_ff;
         end
         ST_MB: begin
            u_active = 1'b1;
            u_mul = 1'b1;
            u_x = b_ff;
         end
         default: begin
            u_active = 1'b0;
         end
      endcase
   end

   // One shift-and-subtract step of the shared unit.
   always_comb begin
      t1 = {acc_ff, (!u_mul) ? u_x[cnt_ff] : 1'b0};
      if (t1 >= {1'b0, u_m}) begin
         t1 = t1 - {1'b0, u_m};
      end
      t2 = t1 + ((u_mul && u_y[cnt_ff]) ? {1'b0, u_x} : '0);
      if (t2 >= {1'b0, u_m}) begin
         t2 = t2 - {1'b0, u_m};
      end
      u_res = t2[W-1:0];
      u_done = run_ff && (cnt_ff == '0);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_candidate <= W'(3) || !req_candidate[0]) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_DIV3;
               end
            end
         end
         ST_DIV3: begin
            if (u_done) begin
               state_in = (u_res == '0) ? ST_AINIT : ST_TDCHK;
            end
         end
         ST_TDCHK: state_in = (sq_ff <= SW'(n_ff)) ? ST_TDA : ST_FIN;
         ST_TDA: begin
            if (u_done) begin
               state_in = (u_res == '0) ? ST_AINIT : ST_TDB;
            end
         end
         ST_TDB: begin
            if (u_done) begin
               state_in = (u_res == '0) ? ST_AINIT : ST_TDCHK;
            end
         end
         ST_AINIT: state_in = ST_ACHK;
         ST_ACHK: begin
            if (a_ok) begin
               state_in = ST_GCD;
            end else if (!(!phase_ff && n_ext > AW'(dense_ff))) begin
               state_in = ST_FIN;
            end
         end
         ST_GCD: begin
            if (gy_ff == '0) begin
               state_in = (gx_ff == W'(1)) ? ST_POW : ST_NEXT;
            end
         end
         ST_POW: begin
            if (e_ff == '0) begin
               state_in = (r_ff != W'(1)) ? ST_FIN : ST_NEXT;
            end else begin
               state_in = e_ff[0] ? ST_MR : ST_MB;
            end
         end
         ST_MR: state_in = u_done ? ST_MB : ST_MR;
         ST_MB: state_in = u_done ? ST_POW : ST_MB;
         ST_NEXT: state_in = ST_ACHK;
         ST_FIN: state_in = out_free ? ST_IDLE : ST_FIN;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      dense_in = dense_ff;
      sparse_in = sparse_ff;
      stride_in = stride_ff;
      n_in = n_ff;
      gx_in = gx_ff;
      gy_in = gy_ff;
      r_in = r_ff;
      b_in = b_ff;
      e_in = e_ff;
      d_in = d_ff;
      a_in = a_ff;
      sq_in = sq_ff;
      phase_in = phase_ff;
      res_in = res_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_DENSE_LIMIT: dense_in = csr_wdata;
            REG_SPARSE_LIMIT: sparse_in = csr_wdata;
            REG_SPARSE_STRIDE: stride_in = csr_wdata[7:0];
            default: dense_in = dense_ff;
         endcase
      end
      if (u_active && !run_ff) begin
         run_in = 1'b1;
         acc_in = '0;
         cnt_in = CW'(W - 1);
      end else if (run_ff) begin
         acc_in = u_res;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            run_in = 1'b0;
         end
      end
      unique case (state_ff)
         ST_IDLE: begin
            n_in = req_candidate;
            res_in = 1'b0;
            d_in = AW'(5);
            sq_in = SW'(25);
         end
         ST_TDB: begin
            if (u_done) begin
               d_in = d_ff + AW'(6);
               sq_in = sq_ff + (SW'(d_ff) << 3) + (SW'(d_ff) << 2) + SW'(36);
            end
         end
         ST_AINIT: begin
            a_in = AW'(2);
            phase_in = 1'b0;
            res_in = 1'b1;
         end
         ST_ACHK: begin
            if (a_ok) begin
               gx_in = n_ff;
               gy_in = a_ff[W-1:0];
            end else if (!phase_ff && n_ext > AW'(dense_ff)) begin
               phase_in = 1'b1;
               a_in = AW'(dense_ff) + AW'(1);
            end
         end
         ST_GCD: begin
            if (gy_ff == '0) begin
               r_in = W'(1);
               b_in = a_ff[W-1:0];
               e_in = n_ff - W'(1);
            end else if (u_done) begin
               gx_in = gy_ff;
               gy_in = u_res;
            end
         end
         ST_POW: begin
            if (e_ff == '0 && r_ff != W'(1)) begin
               res_in = 1'b0;
            end
         end
         ST_MR: begin
            if (u_done) begin
               r_in = u_res;
            end
         end
         ST_MB: begin
            if (u_done) begin
               b_in = u_res;
               e_in = e_ff >> 1;
            end
         end
         ST_NEXT: a_in = a_ff + a_step;
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_ff;
            end
         end
         default: res_in = res_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dense_ff <= DENSE_LIMIT_RESET;
         sparse_ff <= SPARSE_LIMIT_RESET;
         stride_ff <= SPARSE_STRIDE_RESET;
         run_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         dense_ff <= dense_in;
         sparse_ff <= sparse_in;
         stride_ff <= stride_in;
         run_ff <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      gx_ff <= gx_in;
      gy_ff <= gy_in;
      r_ff <= r_in;
      b_ff <= b_in;
      e_ff <= e_in;
      d_ff <= d_in;
      a_ff <= a_in;
      sq_ff <= sq_in;
      phase_ff <= phase_in;
      res_ff <= res_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule

// ===== hdl/cmt_checker.sv =====
// Port-level checker of the Carmichael number test unit and its bind.
module cmt_checker #(
   parameter int NUMBER_WIDTH = cmt_pkg::NUMBER_WIDTH_DEFAULT
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic [NUMBER_WIDTH-1:0] req_candidate,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic                    rsp_is_carmichael
);
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("Unit not idle after reset.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("Unit not busy after an accepted item.");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("Result item appeared without work in progress.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_is_carmichael))
      else $error("Stalled result item changed.");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> req_valid && $stable(req_candidate))
      else $error("Stalled input item changed.");
endmodule

bind carmichael_number_test_unit cmt_checker #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_cmt_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_candidate(req_candidate),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_is_carmichael(rsp_is_carmichael)
);

// ===== sim/carmichael_number_test_unit_tb.sv =====
// Testbench for the Carmichael number test unit: directed table, random items, own predictor.
`timescale 1ns / 1ps

module carmichael_number_test_unit_tb;
   import cmt_pkg::*;

   localparam int W = NUMBER_WIDTH_DEFAULT;
   localparam longint CYCLE_LIMIT = 40_000_000;
   localparam int NUM_PHASES = 7;

   typedef struct {
      int          phase;
      logic [W-1:0] cand;
      bit          known;
      bit          verdict;
   } row_type;

   typedef struct {
      logic [15:0] dense;
      logic [15:0] sparse;
      logic [15:0] stride;
      bit          carm_ok;
   } setting_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [W-1:0] req_candidate = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic rsp_is_carmichael;
   logic csr_valid = 0;
   logic csr_ready;
   logic [1:0] csr_index = REG_DENSE_LIMIT;
   logic [15:0] csr_wdata = '0;

   logic [15:0] dense_lim;
   logic [15:0] sparse_lim;
   logic [7:0] stride_reg;

   bit verdict_q[$];
   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int ones_seen = 0;
   longint cycles = 0;
   bit quiet = 0;
   int stall_left = 0;

   row_type rows[$];
   setting_type settings[NUM_PHASES];
   int carm_list[7] = '{561, 1105, 1729, 2465, 2821, 6601, 8911};

   carmichael_number_test_unit #(.NUMBER_WIDTH(W)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_candidate(req_candidate),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_is_carmichael(rsp_is_carmichael),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic longint unsigned mod_power(longint unsigned b, longint unsigned e,
                                                 longint unsigned n);
      longint unsigned r;
      r = 1 % n;
      b = b % n;
      while (e != 0) begin
         if (e[0]) r = (r * b) % n;
         e = e >> 1;
         b = (b * b) % n;
      end
      return r;
   endfunction

   function automatic bit is_composite(longint unsigned n);
      longint unsigned d;
      if (n <= 3) return 0;
      if (n % 2 == 0 || n % 3 == 0) return 1;
      for (d = 5; d * d <= n; d += 6)
         if (n % d == 0 || n % (d + 2) == 0) return 1;
      return 0;
   endfunction

   function automatic bit witness_fails(longint unsigned a, longint unsigned n);
      return gcd64(a, n) == 1 && mod_power(a, n - 1, n) != 1;
   endfunction

   function automatic bit carmichael_verdict(logic [W-1:0] cand);
      longint unsigned n, a, step;
      n = cand;
      if (!is_composite(n)) return 0;
      if (n[0] == 0) return 0;
      for (a = 2; a < n && a <= dense_lim; a++)
         if (witness_fails(a, n)) return 0;
      if (n > dense_lim) begin
         step = (stride_reg == 0) ? 1 : stride_reg;
         for (a = longint'(dense_lim) + 1; a < n && a <= sparse_lim; a += step)
            if (witness_fails(a, n)) return 0;
      end
      return 1;
   endfunction

   task automatic report_mismatch(string what);
      $display("MISMATCH at cycle %0d: %s", cycles, what);
      errors++;
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("carmichael_number_test_unit_tb: done, errors");
         $finish;
      end
   end

   // Receiver: random stall stretches, none while quiet is set.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_is_carmichael) ones_seen++;
         if (verdict_q.size() == 0)
            report_mismatch("result item with nothing expected");
         else begin
            bit want;
            want = verdict_q.pop_front();
            if (rsp_is_carmichael !== want)
               report_mismatch($sformatf("is_carmichael %b, expected %b",
                                         rsp_is_carmichael, want));
         end
      end
      if (quiet) begin
         rsp_stall <= 0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall <= 1;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                    : $urandom_range(0, 2);
      end else
         rsp_stall <= 0;
   end

   task automatic wait_drained();
      while (verdict_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_DENSE_LIMIT: dense_lim = value;
         REG_SPARSE_LIMIT: sparse_lim = value;
         REG_SPARSE_STRIDE: stride_reg = value[7:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(int p);
      req_valid <= 0;
      wait_drained();
      @(posedge clock);
      write_reg(REG_DENSE_LIMIT, settings[p].dense);
      write_reg(REG_SPARSE_LIMIT, settings[p].sparse);
      write_reg(REG_SPARSE_STRIDE, settings[p].stride);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic send_item(logic [W-1:0] cand, bit known, bit verdict);
      int gap;
      gap = quiet ? 0 : (($urandom_range(0, 9) < 7) ? $urandom_range(0, 2)
                                                     : $urandom_range(10, 40));
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_candidate <= cand;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (known && carmichael_verdict(cand) != verdict)
         report_mismatch($sformatf("table entry %0d disagrees with predictor", cand));
      verdict_q.push_back(known ? verdict : carmichael_verdict(cand));
      items_sent++;
   endtask

   function automatic logic [W-1:0] random_candidate(bit carm_ok);
      int r;
      logic [W-1:0] c;
      r = $urandom_range(0, 9);
      if (carm_ok && r < 3)
         c = W'(carm_list[$urandom_range(0, 6)]);
      else if (r == 3)
         c = W'(($urandom_range(1, 30) * 2 + 1) * ($urandom_range(1, 30) * 2 + 1));
      else if (r == 4)
         c = W'({$urandom} & ~32'd1);
      else
         c = W'($urandom & 32'h3FF);
      if (!carm_ok)
         foreach (carm_list[i])
            if (c == carm_list[i]) c = c + W'(1);
      return c;
   endfunction

   initial begin
      int cur;
      settings[0] = '{16'd100, 16'd1000, 16'd10, 0};
      settings[1] = '{16'd5, 16'd30, 16'd0, 1};
      settings[2] = '{16'd1, 16'd1, 16'd1, 1};
      settings[3] = '{16'd65535, 16'd65535, 16'd255, 0};
      settings[4] = '{16'd10, 16'd65535, 16'd255, 1};
      settings[5] = '{16'd2, 16'd2, 16'd1, 1};
      settings[6] = '{16'd100, 16'd1000, 16'd10, 0};

      rows = '{
         '{0, 0, 1, 0}, '{0, 1, 1, 0}, '{0, 2, 1, 0}, '{0, 3, 1, 0}, '{0, 4, 1, 0},
         '{0, 2147483645, 1, 0}, '{0, 2147483646, 1, 0}, '{0, 9, 0, 0},
         '{0, 15, 0, 0}, '{0, 25, 0, 0},
         '{1, 561, 0, 0}, '{1, 1105, 0, 0}, '{1, 1729, 0, 0}, '{1, 341, 0, 0},
         '{1, 45, 0, 0}, '{1, 91, 0, 0}, '{1, 7, 1, 0},
         '{2, 561, 1, 1}, '{2, 9, 1, 1}, '{2, 8, 1, 0}, '{2, 13, 1, 0},
         '{5, 2821, 0, 0}, '{5, 3, 1, 0}, '{5, 15, 0, 0}
      };

      dense_lim = DENSE_LIMIT_RESET;
      sparse_lim = SPARSE_LIMIT_RESET;
      stride_reg = SPARSE_STRIDE_RESET;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      cur = 0;
      foreach (rows[i]) begin
         if (rows[i].phase != cur) begin
            cur = rows[i].phase;
            apply_setting(cur);
         end
         send_item(rows[i].cand, rows[i].known, rows[i].verdict);
      end

      for (int p = 1; p < NUM_PHASES; p++) begin
         apply_setting(p);
         quiet = (p == 4);
         repeat (16) send_item(random_candidate(settings[p].carm_ok), 0, 0);
         quiet = 0;
      end
      req_valid <= 0;

      wait_drained();
      repeat (100) @(posedge clock);

      $display("%0d items sent, %0d results checked, %0d flagged Carmichael,",
               items_sent, results_seen, ones_seen);
      $display("over %0d register settings from the lowest limits to the highest.",
               NUM_PHASES);
      if (errors == 0 && verdict_q.size() == 0)
         $display("carmichael_number_test_unit_tb: done, clean");
      else
         $display("carmichael_number_test_unit_tb: done, errors");
      $finish;
   end
endmodule
